[sv/optd_pkg.sv]
// Shared types, codes and constants of the pulse telegram decoder.
package optd_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int FRAME_WIDTH_DEF = 32;

    localparam int UNIT_W   = 11;
    localparam int MARGIN_W = 10;
    localparam int CODE_W   = 4;
    localparam int BITS_W   = 6;
    localparam int CIDX_W   = 2;
    // Widest nominal duration is 40 units of the largest unit time.
    localparam int NOM_W    = 17;

    localparam logic [UNIT_W-1:0]   UNIT_TIME_RST    = 11'd250;
    localparam logic [MARGIN_W-1:0] EARLY_MARGIN_RST = 10'd150;
    localparam logic [MARGIN_W-1:0] LATE_MARGIN_RST  = 10'd250;

    localparam int SPACE_UNITS = 5;
    localparam int SYNC_UNITS  = 10;
    localparam int PAUSE_UNITS = 40;
    localparam int PAUSE_SLACK = 50;

    localparam logic [BITS_W-1:0] BITS_MAX = 6'd63;

    localparam int CODE_Q_DEPTH = 4;
    localparam int OUT_Q_DEPTH  = 2;

    typedef enum logic [CODE_W-1:0] {
        PC_NONE  = 4'd0,
        PC_MARK  = 4'd1,
        PC_SPACE = 4'd2,
        PC_SYNC  = 4'd3,
        PC_PAUSE = 4'd4,
        PC_EDGE1 = 4'd5,
        PC_EDGE2 = 4'd6,
        PC_EDGE3 = 4'd7,
        PC_HIGH  = 4'd8,
        PC_LOW   = 4'd9
    } pulse_code_t;

    typedef enum logic [1:0] {
        PP_WAIT_RISE = 2'd0,
        PP_WAIT_FALL = 2'd1,
        PP_WAIT_LOW  = 2'd2
    } pulse_phase_t;

    typedef enum logic [1:0] {
        FP_WAIT_SYNC  = 2'd0,
        FP_WAIT_BIT   = 2'd1,
        FP_WAIT_SPACE = 2'd2,
        FP_WAIT_MARK  = 2'd3
    } frame_phase_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_UNIT_TIME    = 2'd0,
        REG_EARLY_MARGIN = 2'd1,
        REG_LATE_MARGIN  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit_time;
        logic [MARGIN_W-1:0] early_margin;
        logic [MARGIN_W-1:0] late_margin;
    } cfg_t;

endpackage

[sv/optd_fifo.sv]
// Small register FIFO used for the code queue and the result queue.
module optd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[sv/optd_front.sv]
// Front end: drops repeated levels and times high and low periods into pulse codes.
module optd_front #(
    parameter int TIME_WIDTH = optd_pkg::TIME_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        line_level,
    input  logic [TIME_WIDTH-1:0]       event_time,
    input  optd_pkg::cfg_t              cfg,
    output logic                        code_push,
    output logic [optd_pkg::CODE_W-1:0] code_data
);

    localparam int NOM_W = optd_pkg::NOM_W;
    localparam int CMP_W = (TIME_WIDTH > NOM_W + 1) ? TIME_WIDTH : NOM_W + 1;

    optd_pkg::pulse_phase_t phase_reg, phase_next;
    logic                   last_level_reg, last_level_next;
    logic [TIME_WIDTH-1:0]  rise_time_reg, rise_time_next;
    logic [TIME_WIDTH-1:0]  fall_time_reg, fall_time_next;
    optd_pkg::pulse_code_t  code;

    logic [TIME_WIDTH-1:0]  dur_high;
    logic [TIME_WIDTH-1:0]  dur_low;
    logic [NOM_W-1:0]       nom1;
    logic [NOM_W-1:0]       nom5;
    logic [NOM_W-1:0]       nom10;
    logic [NOM_W-1:0]       nom40;
    logic                   high_ok;
    logic                   low_mark;
    logic                   low_space;
    logic                   low_sync;
    logic                   low_pause;

    function automatic logic in_window(
        input logic [TIME_WIDTH-1:0] dur,
        input logic [NOM_W-1:0]      nom,
        input logic [optd_pkg::MARGIN_W-1:0] early,
        input logic [optd_pkg::MARGIN_W-1:0] late
    );
        logic [NOM_W-1:0] lo;
        logic [NOM_W:0]   hi;
        lo = (nom >= NOM_W'(early)) ? nom - NOM_W'(early) : '0;
        hi = {1'b0, nom} + (NOM_W + 1)'(late);
        return (CMP_W'(dur) >= CMP_W'(lo)) && (CMP_W'(dur) <= CMP_W'(hi));
    endfunction

    assign dur_high = event_time - rise_time_reg;
    assign dur_low  = event_time - fall_time_reg;

    assign nom1  = NOM_W'(cfg.unit_time);
    assign nom5  = nom1 * NOM_W'(optd_pkg::SPACE_UNITS);
    assign nom10 = nom1 * NOM_W'(optd_pkg::SYNC_UNITS);
    assign nom40 = nom1 * NOM_W'(optd_pkg::PAUSE_UNITS);

    assign high_ok   = in_window(dur_high, nom1, cfg.early_margin, cfg.late_margin);
    assign low_mark  = in_window(dur_low, nom1, cfg.early_margin, cfg.late_margin);
    assign low_space = in_window(dur_low, nom5, cfg.early_margin, cfg.late_margin);
    assign low_sync  = in_window(dur_low, nom10, cfg.early_margin, cfg.late_margin);
    // A unit time too short to leave room for the slack makes every low a pause.
    assign low_pause = (nom40 < NOM_W'(optd_pkg::PAUSE_SLACK)) ||
                       (CMP_W'(dur_low) > CMP_W'(nom40 - NOM_W'(optd_pkg::PAUSE_SLACK)));

    always_comb
    begin
        phase_next      = phase_reg;
        last_level_next = last_level_reg;
        rise_time_next  = rise_time_reg;
        fall_time_next  = fall_time_reg;
        code            = optd_pkg::PC_NONE;
        code_push       = 1'b0;
        if (accept && (line_level != last_level_reg))
        begin
            code_push       = 1'b1;
            last_level_next = line_level;
            case (phase_reg)
                optd_pkg::PP_WAIT_FALL:
                begin
                    if (!line_level)
                    begin
                        fall_time_next = event_time;
                        if (high_ok)
                        begin
                            phase_next = optd_pkg::PP_WAIT_LOW;
                        end
                        else
                        begin
                            code       = optd_pkg::PC_HIGH;
                            phase_next = optd_pkg::PP_WAIT_RISE;
                        end
                    end
                    else
                    begin
                        code       = optd_pkg::PC_EDGE2;
                        phase_next = optd_pkg::PP_WAIT_RISE;
                    end
                end
                optd_pkg::PP_WAIT_LOW:
                begin
                    if (line_level)
                    begin
                        if (low_mark)
                        begin
                            code = optd_pkg::PC_MARK;
                        end
                        else if (low_space)
                        begin
                            code = optd_pkg::PC_SPACE;
                        end
                        else if (low_sync)
                        begin
                            code = optd_pkg::PC_SYNC;
                        end
                        else if (low_pause)
                        begin
                            code = optd_pkg::PC_PAUSE;
                        end
                        else
                        begin
                            code = optd_pkg::PC_LOW;
                        end
                    end
                    else
                    begin
                        code = optd_pkg::PC_EDGE3;
                    end
                    rise_time_next = event_time;
                    phase_next     = optd_pkg::PP_WAIT_FALL;
                end
                default:
                begin
                    if (line_level)
                    begin
                        phase_next     = optd_pkg::PP_WAIT_FALL;
                        rise_time_next = event_time;
                    end
                    else
                    begin
                        code       = optd_pkg::PC_EDGE1;
                        phase_next = optd_pkg::PP_WAIT_RISE;
                    end
                end
            endcase
        end
    end

    assign code_data = code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= optd_pkg::PP_WAIT_RISE;
            last_level_reg <= 1'b0;
            rise_time_reg  <= '0;
            fall_time_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            last_level_reg <= last_level_next;
            rise_time_reg  <= rise_time_next;
            fall_time_reg  <= fall_time_next;
        end
    end

endmodule

[sv/optd_back.sv]
// Back end: frame machine that gathers pulse codes into telegrams.
module optd_back #(
    parameter int FRAME_WIDTH = optd_pkg::FRAME_WIDTH_DEF,
    parameter int RES_W       = optd_pkg::CODE_W + 1 + FRAME_WIDTH + optd_pkg::BITS_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        code_empty,
    input  logic [optd_pkg::CODE_W-1:0] code_data,
    output logic                        code_pop,
    input  logic                        res_full,
    output logic                        res_push,
    output logic [RES_W-1:0]            res_data
);

    localparam int BITS_W = optd_pkg::BITS_W;

    optd_pkg::frame_phase_t phase_reg, phase_next;
    logic [FRAME_WIDTH-1:0] accum_reg, accum_next;
    logic [BITS_W-1:0]      bits_reg, bits_next;
    optd_pkg::pulse_code_t  code;
    logic                   step;
    logic                   done;
    logic [FRAME_WIDTH-1:0] bit_sel;
    logic [BITS_W-1:0]      bits_inc;

    assign step     = !code_empty && !res_full;
    assign code_pop = step;
    assign res_push = step;
    assign code     = optd_pkg::pulse_code_t'(code_data);

    // Bits past the frame width select nothing, so they are only counted.
    always_comb
    begin
        for (int i = 0; i < FRAME_WIDTH; i++)
        begin
            bit_sel[i] = (bits_reg == BITS_W'(i));
        end
    end

    assign bits_inc = (bits_reg < optd_pkg::BITS_MAX) ? bits_reg + 1'b1 : bits_reg;

    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        bits_next  = bits_reg;
        done       = 1'b0;
        if (step && (code != optd_pkg::PC_NONE))
        begin
            case (phase_reg)
                optd_pkg::FP_WAIT_SYNC:
                begin
                    if (code == optd_pkg::PC_SYNC)
                    begin
                        phase_next = optd_pkg::FP_WAIT_BIT;
                        accum_next = '0;
                        bits_next  = '0;
                    end
                end
                optd_pkg::FP_WAIT_BIT:
                begin
                    if (code == optd_pkg::PC_MARK)
                    begin
                        phase_next = optd_pkg::FP_WAIT_SPACE;
                    end
                    else if (code == optd_pkg::PC_SPACE)
                    begin
                        phase_next = optd_pkg::FP_WAIT_MARK;
                    end
                    else
                    begin
                        phase_next = optd_pkg::FP_WAIT_SYNC;
                        done       = (code == optd_pkg::PC_PAUSE);
                    end
                end
                optd_pkg::FP_WAIT_SPACE:
                begin
                    if (code == optd_pkg::PC_SPACE)
                    begin
                        phase_next = optd_pkg::FP_WAIT_BIT;
                        accum_next = accum_reg | bit_sel;
                        bits_next  = bits_inc;
                    end
                    else
                    begin
                        phase_next = optd_pkg::FP_WAIT_SYNC;
                    end
                end
                default:
                begin
                    if (code == optd_pkg::PC_MARK)
                    begin
                        phase_next = optd_pkg::FP_WAIT_BIT;
                        bits_next  = bits_inc;
                    end
                    else
                    begin
                        phase_next = optd_pkg::FP_WAIT_SYNC;
                    end
                end
            endcase
        end
    end

    // A frame ends on a pause, which leaves the accumulator and count unchanged.
    assign res_data = {code_data, done,
                       done ? accum_reg : {FRAME_WIDTH{1'b0}},
                       done ? bits_reg : {BITS_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= optd_pkg::FP_WAIT_SYNC;
            accum_reg <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            bits_reg  <= bits_next;
        end
    end

    a_done_on_pause: assert property (@(posedge clk) disable iff (!rst_n)
        (step && done) |-> (code == optd_pkg::PC_PAUSE))
        else $error("frame delivered on a code other than pause");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (bits_reg != $past(bits_reg)) |->
        ((bits_reg == '0) || (bits_reg == BITS_W'($past(bits_reg) + 1'b1))))
        else $error("bit count moved other than by one or a restart");

    a_sync_start: assert property (@(posedge clk) disable iff (!rst_n)
        (($past(phase_reg) == optd_pkg::FP_WAIT_SYNC) &&
         (phase_reg != optd_pkg::FP_WAIT_SYNC)) |->
        ((phase_reg == optd_pkg::FP_WAIT_BIT) && (bits_reg == '0) && (accum_reg == '0)))
        else $error("frame left sync wait without a clean start");

endmodule

[sv/ook_pulse_telegram_decoder_unit.sv]
// Top level of the pulse telegram decoder: config registers, front end, queues, back end.
//
//  Channel   Handshake               Payload
//  input     push / full             line_level, event_time
//  result    pop / empty             pulse_code, frame_valid, frame_data, frame_bits
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One edge event is accepted per cycle unless full; a level change sends its code through
// the code queue and the back end into the result queue. The front end times the edge in
// the cycle it is accepted; the back end takes one code per cycle, while the result queue
// has room, from a four-entry code queue into a two-entry result queue. full rises only
// when the code queue holds four codes while results are not taken. Reset is
// asynchronous; it clears all control state and resets the config registers.
module ook_pulse_telegram_decoder_unit #(
    parameter int TIME_WIDTH  = optd_pkg::TIME_WIDTH_DEF,
    parameter int FRAME_WIDTH = optd_pkg::FRAME_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          line_level,
    input  logic [TIME_WIDTH-1:0]         event_time,
    input  logic                          pop,
    output logic                          empty,
    output logic [optd_pkg::CODE_W-1:0]   pulse_code,
    output logic                          frame_valid,
    output logic [FRAME_WIDTH-1:0]        frame_data,
    output logic [optd_pkg::BITS_W-1:0]   frame_bits,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [optd_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [optd_pkg::UNIT_W-1:0]   cfg_data
);

    localparam int CODE_W = optd_pkg::CODE_W;
    localparam int BITS_W = optd_pkg::BITS_W;
    localparam int RES_W  = CODE_W + 1 + FRAME_WIDTH + BITS_W;

    optd_pkg::cfg_t    cfg_reg;
    logic              accept;
    logic              code_push;
    logic [CODE_W-1:0] code_wdata;
    logic              code_full;
    logic              code_pop;
    logic [CODE_W-1:0] code_rdata;
    logic              code_empty;
    logic              res_push;
    logic [RES_W-1:0]  res_wdata;
    logic              res_full;
    logic [RES_W-1:0]  res_rdata;

    assign cfg_ready = 1'b1;
    assign full      = code_full;
    assign accept    = push && !code_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_time    <= optd_pkg::UNIT_TIME_RST;
            cfg_reg.early_margin <= optd_pkg::EARLY_MARGIN_RST;
            cfg_reg.late_margin  <= optd_pkg::LATE_MARGIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                optd_pkg::REG_UNIT_TIME:
                begin
                    cfg_reg.unit_time <= cfg_data;
                end
                optd_pkg::REG_EARLY_MARGIN:
                begin
                    cfg_reg.early_margin <= cfg_data[optd_pkg::MARGIN_W-1:0];
                end
                optd_pkg::REG_LATE_MARGIN:
                begin
                    cfg_reg.late_margin <= cfg_data[optd_pkg::MARGIN_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    optd_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .line_level (line_level),
        .event_time (event_time),
        .cfg        (cfg_reg),
        .code_push  (code_push),
        .code_data  (code_wdata)
    );

    optd_fifo #(
        .WIDTH (CODE_W),
        .DEPTH (optd_pkg::CODE_Q_DEPTH)
    ) u_code_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (code_push),
        .wdata (code_wdata),
        .full  (code_full),
        .pop   (code_pop),
        .rdata (code_rdata),
        .empty (code_empty)
    );

    optd_back #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .RES_W       (RES_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_empty (code_empty),
        .code_data  (code_rdata),
        .code_pop   (code_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_wdata)
    );

    optd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (optd_pkg::OUT_Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign pulse_code  = res_rdata[RES_W-1 -: CODE_W];
    assign frame_valid = res_rdata[FRAME_WIDTH + BITS_W];
    assign frame_data  = res_rdata[BITS_W +: FRAME_WIDTH];
    assign frame_bits  = res_rdata[BITS_W-1:0];

endmodule

[sim/ook_pulse_telegram_decoder_checker.sv]
`timescale 1ns / 100ps
// Checker for the pulse telegram decoder: edge timing and frame prediction, result comparison.
module ook_pulse_telegram_decoder_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  logic                                 line_level,
    input  logic [optd_pkg::TIME_WIDTH_DEF-1:0]  event_time,
    input  logic                                 pop,
    input  logic                                 empty,
    input  logic [optd_pkg::CODE_W-1:0]          pulse_code,
    input  logic                                 frame_valid,
    input  logic [optd_pkg::FRAME_WIDTH_DEF-1:0] frame_data,
    input  logic [optd_pkg::BITS_W-1:0]          frame_bits,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [optd_pkg::CIDX_W-1:0]          cfg_index,
    input  logic [optd_pkg::UNIT_W-1:0]          cfg_data,
    output int                                   errors,
    output int                                   outstanding,
    output int                                   checked,
    output int                                   frames
);

    localparam int TW = optd_pkg::TIME_WIDTH_DEF;
    localparam int FW = optd_pkg::FRAME_WIDTH_DEF;

    typedef struct packed {
        logic [optd_pkg::CODE_W-1:0] code;
        logic                        valid;
        logic [FW-1:0]               data;
        logic [optd_pkg::BITS_W-1:0] bits;
    } decoder_result_t;

    logic [optd_pkg::UNIT_W-1:0]   unit_q;
    logic [optd_pkg::MARGIN_W-1:0] early_q;
    logic [optd_pkg::MARGIN_W-1:0] late_q;
    optd_pkg::pulse_phase_t        pphase;
    logic                          level_q;
    logic [TW-1:0]                 rise_q;
    logic [TW-1:0]                 fall_q;
    optd_pkg::frame_phase_t        fphase;
    logic [FW-1:0]                 accum_q;
    logic [optd_pkg::BITS_W-1:0]   nbits_q;

    decoder_result_t expected_results[$];

    initial begin
        errors  = 0;
        checked = 0;
        frames  = 0;
    end

    function automatic bit fits(input logic [TW-1:0] dur,
                                input int unsigned nominal);
        longint unsigned lo;
        longint unsigned hi;
        lo = (nominal >= 32'(early_q)) ? 64'(nominal - 32'(early_q)) : 64'd0;
        hi = 64'(nominal) + 64'(late_q);
        return (64'(dur) >= lo) && (64'(dur) <= hi);
    endfunction

    function automatic void add_bit(input bit one);
        if (one && nbits_q < FW)
            accum_q = accum_q | (FW'(1) << nbits_q);
        if (nbits_q < optd_pkg::BITS_MAX)
            nbits_q = nbits_q + 1'b1;
    endfunction

    // Returns 1 when the code finishes a frame.
    function automatic bit feed_frame(input optd_pkg::pulse_code_t code);
        bit done = 1'b0;
        case (fphase)
            optd_pkg::FP_WAIT_SYNC:
                if (code == optd_pkg::PC_SYNC)
                begin
                    fphase  = optd_pkg::FP_WAIT_BIT;
                    accum_q = '0;
                    nbits_q = '0;
                end
            optd_pkg::FP_WAIT_BIT:
                if (code == optd_pkg::PC_MARK)
                    fphase = optd_pkg::FP_WAIT_SPACE;
                else if (code == optd_pkg::PC_SPACE)
                    fphase = optd_pkg::FP_WAIT_MARK;
                else
                begin
                    fphase = optd_pkg::FP_WAIT_SYNC;
                    done   = (code == optd_pkg::PC_PAUSE);
                end
            optd_pkg::FP_WAIT_SPACE:
                if (code == optd_pkg::PC_SPACE)
                begin
                    fphase = optd_pkg::FP_WAIT_BIT;
                    add_bit(1'b1);
                end
                else
                    fphase = optd_pkg::FP_WAIT_SYNC;
            default:
                if (code == optd_pkg::PC_MARK)
                begin
                    fphase = optd_pkg::FP_WAIT_BIT;
                    add_bit(1'b0);
                end
                else
                    fphase = optd_pkg::FP_WAIT_SYNC;
        endcase
        return done;
    endfunction

    // Times one edge; returns 0 for a repeated level, which causes no result.
    function automatic bit decode_edge(input logic level,
                                       input logic [TW-1:0] now,
                                       output decoder_result_t r);
        optd_pkg::pulse_code_t code = optd_pkg::PC_NONE;
        bit                    done = 1'b0;
        logic [TW-1:0]         dur;
        int unsigned           unit;
        longint unsigned       pause_len;
        r    = '0;
        unit = 32'(unit_q);
        if (level == level_q)
            return 1'b0;
        case (pphase)
            optd_pkg::PP_WAIT_FALL:
                if (!level)
                begin
                    fall_q = now;
                    dur    = now - rise_q;
                    if (fits(dur, unit))
                        pphase = optd_pkg::PP_WAIT_LOW;
                    else
                    begin
                        code   = optd_pkg::PC_HIGH;
                        pphase = optd_pkg::PP_WAIT_RISE;
                    end
                end
                else
                begin
                    code   = optd_pkg::PC_EDGE2;
                    pphase = optd_pkg::PP_WAIT_RISE;
                end
            optd_pkg::PP_WAIT_LOW:
            begin
                if (level)
                begin
                    dur       = now - fall_q;
                    pause_len = 64'(optd_pkg::PAUSE_UNITS * unit);
                    if (fits(dur, unit))
                        code = optd_pkg::PC_MARK;
                    else if (fits(dur, optd_pkg::SPACE_UNITS * unit))
                        code = optd_pkg::PC_SPACE;
                    else if (fits(dur, optd_pkg::SYNC_UNITS * unit))
                        code = optd_pkg::PC_SYNC;
                    else if (pause_len < optd_pkg::PAUSE_SLACK ||
                             64'(dur) > pause_len - optd_pkg::PAUSE_SLACK)
                        code = optd_pkg::PC_PAUSE;
                    else
                        code = optd_pkg::PC_LOW;
                end
                else
                    code = optd_pkg::PC_EDGE3;
                rise_q = now;
                pphase = optd_pkg::PP_WAIT_FALL;
            end
            default:
                if (level)
                begin
                    pphase = optd_pkg::PP_WAIT_FALL;
                    rise_q = now;
                end
                else
                begin
                    code   = optd_pkg::PC_EDGE1;
                    pphase = optd_pkg::PP_WAIT_RISE;
                end
        endcase
        level_q = level;
        if (code != optd_pkg::PC_NONE)
            done = feed_frame(code);
        r.code  = code;
        r.valid = done;
        r.data  = done ? accum_q : '0;
        r.bits  = done ? nbits_q : '0;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        decoder_result_t want;
        decoder_result_t got;
        int              added;
        int              removed;
        if (!rst_n)
        begin
            unit_q      = optd_pkg::UNIT_TIME_RST;
            early_q     = optd_pkg::EARLY_MARGIN_RST;
            late_q      = optd_pkg::LATE_MARGIN_RST;
            pphase      = optd_pkg::PP_WAIT_RISE;
            level_q     = 1'b0;
            rise_q      = '0;
            fall_q      = '0;
            fphase      = optd_pkg::FP_WAIT_SYNC;
            accum_q     = '0;
            nbits_q     = '0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            added   = 0;
            removed = 0;
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    optd_pkg::REG_UNIT_TIME:    unit_q  = cfg_data;
                    optd_pkg::REG_EARLY_MARGIN: early_q = cfg_data[optd_pkg::MARGIN_W-1:0];
                    optd_pkg::REG_LATE_MARGIN:  late_q  = cfg_data[optd_pkg::MARGIN_W-1:0];
                    default: ;
                endcase
            // Results are taken before new edges so that a result can never match an
            // edge accepted at the same clock edge.
            if (pop && !empty)
            begin
                got = '{pulse_code, frame_valid, frame_data, frame_bits};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result: code %0d valid %0b data %h bits %0d",
                                 $time, got.code, got.valid, got.data, got.bits);
                end
                else
                begin
                    want = expected_results.pop_front();
                    removed = 1;
                    checked++;
                    if (want.valid)
                        frames++;
                    if (got.code !== want.code || got.valid !== want.valid ||
                        got.data !== want.data || got.bits !== want.bits)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: result mismatch: expected code %0d valid %0b data %h bits %0d",
                                     $time, want.code, want.valid, want.data, want.bits);
                            $display("%0t:   actual code %0d valid %0b data %h bits %0d",
                                     $time, got.code, got.valid, got.data, got.bits);
                        end
                    end
                end
            end
            if (push && !full)
                if (decode_edge(line_level, event_time, want))
                begin
                    expected_results.push_back(want);
                    added = 1;
                end
            outstanding <= outstanding + added - removed;
        end
    end

endmodule

[sim/tb_ook_pulse_telegram_decoder_unit.sv]
`timescale 1ns / 100ps
// Testbench top for the pulse telegram decoder: stimulus, flow control and verdict.
module tb_ook_pulse_telegram_decoder_unit;

    localparam int CLK_HALF        = 10;
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 400;
    localparam int EDGES_PER_PHASE = 200;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TW              = optd_pkg::TIME_WIDTH_DEF;
    localparam int UW              = optd_pkg::UNIT_W;
    // Index with no register behind it; writes to it must be ignored.
    localparam logic [optd_pkg::CIDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_TOGGLE} pop_style_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 push = 1'b0;
    logic                                 full;
    logic                                 line_level = 1'b0;
    logic [TW-1:0]                        event_time = '0;
    logic                                 pop = 1'b0;
    logic                                 empty;
    logic [optd_pkg::CODE_W-1:0]          pulse_code;
    logic                                 frame_valid;
    logic [optd_pkg::FRAME_WIDTH_DEF-1:0] frame_data;
    logic [optd_pkg::BITS_W-1:0]          frame_bits;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [optd_pkg::CIDX_W-1:0]          cfg_index = '0;
    logic [UW-1:0]                        cfg_data = '0;

    int errors;
    int outstanding;
    int checked;
    int frames;

    // Stimulus-side view of the line and of the current register settings.
    logic [TW-1:0] stamp_us = '0;
    logic          line_now = 1'b0;
    int unsigned   t_unit  = 32'(optd_pkg::UNIT_TIME_RST);
    int unsigned   t_early = 32'(optd_pkg::EARLY_MARGIN_RST);
    int unsigned   t_late  = 32'(optd_pkg::LATE_MARGIN_RST);
    int            burst_left = 0;
    int            edges_sent = 0;
    int            telegrams_sent = 0;
    int            settings_used = 1;
    int            hold_request = 0;
    int            period_no;
    int            spoil_at;
    int            quiet = 0;

    ook_pulse_telegram_decoder_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .line_level  (line_level),
        .event_time  (event_time),
        .pop         (pop),
        .empty       (empty),
        .pulse_code  (pulse_code),
        .frame_valid (frame_valid),
        .frame_data  (frame_data),
        .frame_bits  (frame_bits),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    ook_pulse_telegram_decoder_checker decode_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .line_level  (line_level),
        .event_time  (event_time),
        .pop         (pop),
        .empty       (empty),
        .pulse_code  (pulse_code),
        .frame_valid (frame_valid),
        .frame_data  (frame_data),
        .frame_bits  (frame_bits),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .frames      (frames)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Ends the run when no transaction of any kind completes for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Result side: changing pop patterns, plus a long hold-off on each request.
    initial
    begin
        pop_style_t style;
        int         left;
        int         hold_seen;
        int         hold_left;
        style     = POP_ALWAYS;
        left      = 0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != hold_seen)
            begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (left == 0)
            begin
                style = pop_style_t'($urandom_range(0, 3));
                left  = $urandom_range(16, 96);
            end
            left--;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                case (style)
                    POP_ALWAYS: pop <= 1'b1;
                    POP_COIN:   pop <= 1'($urandom_range(0, 1));
                    POP_SPARSE: pop <= ($urandom_range(0, 7) == 0);
                    default:    pop <= ~pop;
                endcase
        end
    end

    // Offers one edge and returns at the clock edge of its transaction; push stays high.
    task automatic send_item(input logic level, input logic [TW-1:0] t_us);
        int idle;
        if (burst_left <= 0)
        begin
            push <= 1'b0;
            idle = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
            repeat (idle) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        push       <= 1'b1;
        line_level <= level;
        event_time <= t_us;
        do @(posedge clk); while (full);
        burst_left--;
        if (level != line_now)
            edges_sent++;
        line_now = level;
        stamp_us = t_us;
    endtask

    task automatic send_after(input logic level, input int unsigned dur);
        send_item(level, stamp_us + dur);
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input int unsigned unit, input int unsigned early,
                                 input int unsigned late, input bit poke_spare);
        logic [optd_pkg::CIDX_W-1:0] idx[4];
        logic [UW-1:0]               val[4];
        int                          n;
        // The margin registers are narrower than the data bus; the top bit must be dropped.
        idx[0] = optd_pkg::REG_UNIT_TIME;
        val[0] = UW'(unit);
        idx[1] = optd_pkg::REG_EARLY_MARGIN;
        val[1] = UW'(early | ($urandom_range(0, 1) << optd_pkg::MARGIN_W));
        idx[2] = optd_pkg::REG_LATE_MARGIN;
        val[2] = UW'(late | ($urandom_range(0, 1) << optd_pkg::MARGIN_W));
        idx[3] = REG_SPARE;
        val[3] = UW'($urandom);
        n = poke_spare ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        t_unit  = unit;
        t_early = early;
        t_late  = late;
        settings_used++;
    endtask

    // A duration somewhere inside the acceptance window of a nominal length.
    function automatic int unsigned around(input int unsigned nominal);
        int unsigned lo;
        lo = (nominal > t_early) ? nominal - t_early : 0;
        return lo + $urandom_range(0, nominal + t_late - lo);
    endfunction

    function automatic int unsigned spoiled();
        case ($urandom_range(0, 3))
            0:       return 3 * t_unit;
            1:       return optd_pkg::SYNC_UNITS * t_unit;
            2:       return 20 * t_unit;
            default: return $urandom_range(0, 60 * t_unit);
        endcase
    endfunction

    function automatic int unsigned pause_gap();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(optd_pkg::PAUSE_UNITS * t_unit, 32'hF000_0000);
        return optd_pkg::PAUSE_UNITS * t_unit + $urandom_range(0, 3 * t_unit);
    endfunction

    // One edge of a telegram; the period it closes is replaced by a bad one when chosen.
    task automatic shaped_edge(input logic level, input int unsigned dur);
        if (period_no == spoil_at)
            dur = spoiled();
        period_no++;
        send_after(level, dur);
    endtask

    task automatic send_telegram(input int nbits, input bit broken);
        bit one;
        period_no = 0;
        spoil_at  = broken ? $urandom_range(1, 4 * nbits + 3) : -1;
        if (!line_now)
            send_after(1'b1, $urandom_range(0, 60 * t_unit));
        shaped_edge(1'b0, around(t_unit));
        shaped_edge(1'b1, around(optd_pkg::SYNC_UNITS * t_unit));
        for (int i = 0; i < nbits; i++)
        begin
            one = 1'($urandom_range(0, 1));
            // A one is mark then space, a zero is space then mark.
            shaped_edge(1'b0, around(t_unit));
            shaped_edge(1'b1, around((one ? 1 : optd_pkg::SPACE_UNITS) * t_unit));
            shaped_edge(1'b0, around(t_unit));
            shaped_edge(1'b1, around((one ? optd_pkg::SPACE_UNITS : 1) * t_unit));
        end
        shaped_edge(1'b0, around(t_unit));
        send_after(1'b1, pause_gap());
        telegrams_sent++;
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 3) == 0)
                send_item(1'($urandom_range(0, 1)), $urandom);
            else
                send_after(1'($urandom_range(0, 1)), $urandom_range(0, 50 * t_unit));
    endtask

    task automatic random_phase(input bit with_hold, input bit with_long);
        int  first;
        bit  held;
        int  nbits;
        first = edges_sent;
        held  = 1'b0;
        if (with_long)
            send_telegram(66, 1'b0);
        while (edges_sent - first < EDGES_PER_PHASE)
        begin
            if (with_hold && !held && edges_sent - first >= 20)
            begin
                hold_request <= hold_request + 1;
                held = 1'b1;
            end
            if ($urandom_range(0, 4) == 0)
                send_noise($urandom_range(1, 12));
            else
            begin
                nbits = ($urandom_range(0, 11) == 0) ? $urandom_range(33, 70)
                                                      : $urandom_range(0, 32);
                send_telegram(nbits, $urandom_range(0, 4) == 0);
            end
        end
        drain();
    endtask

    // Short fixed sequence at the reset settings: unit 250, margins 150 and 250.
    task automatic directed();
        send_item(1'b0, 32'h0000_0000);     // repeated level, ignored
        send_item(1'b1, 32'hFFFF_FFFF);
        send_after(1'b0, 250);              // high period across the timestamp wrap
        send_after(1'b1, 2500);             // sync
        send_after(1'b0, 250);
        send_after(1'b1, 250);              // mark
        send_after(1'b0, 250);
        send_after(1'b1, 1250);             // space: logical one
        send_after(1'b0, 250);
        send_after(1'b1, 1250);             // space
        send_after(1'b0, 250);
        send_after(1'b1, 250);              // mark: logical zero
        send_after(1'b0, 250);
        send_after(1'b1, 12000);            // pause delivers the two-bit frame
        send_after(1'b0, 900);              // high period too long
        send_after(1'b0, 10);               // repeated level
        send_after(1'b1, 300);
        send_after(1'b0, 250);
        send_after(1'b1, 750);              // low period between windows
        send_after(1'b0, 250);
        send_after(1'b1, 2500);             // sync
        send_after(1'b0, 250);
        send_after(1'b1, 2500);             // sync where a bit is due drops the frame
        send_after(1'b0, 250);
        send_after(1'b1, 10250);            // pause with no frame open
        drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        random_phase(1'b1, 1'b1);
        load_settings(50, 0, 0, 1'b1);
        random_phase(1'b0, 1'b0);
        load_settings(2000, 1000, 1000, 1'b0);
        random_phase(1'b1, 1'b0);
        load_settings(50, 1000, 1000, 1'b0);
        random_phase(1'b0, 1'b0);
        repeat (2)
        begin
            load_settings($urandom_range(50, 2000), $urandom_range(0, 1000),
                          $urandom_range(0, 1000), 1'b1);
            random_phase(1'b0, 1'b0);
        end
        load_settings(32'(optd_pkg::UNIT_TIME_RST), 32'(optd_pkg::EARLY_MARGIN_RST),
                      32'(optd_pkg::LATE_MARGIN_RST), 1'b0);
        random_phase(1'b0, 1'b1);

        $display("Run covered %0d line edges in %0d telegrams under %0d register settings.",
                 edges_sent, telegrams_sent, settings_used);
        $display("%0d results compared, %0d of them complete frames, %0d mismatches.",
                 checked, frames, errors);
        if (errors == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
sv/optd_pkg.sv
sv/optd_fifo.sv
sv/optd_front.sv
sv/optd_back.sv
sv/ook_pulse_telegram_decoder_unit.sv
sim/ook_pulse_telegram_decoder_checker.sv
sim/tb_ook_pulse_telegram_decoder_unit.sv
